// File: rtl/core/ltc_pkg.sv
// Shared types, constants and keyword table for the lexical token classifier.
// Used by ltc_front, ltc_queue, ltc_back and lexical_token_classifier.
package ltc_pkg;

    localparam int KEYWORD_COUNT = 8;
    localparam int KEYWORD_CHARS = 6;
    localparam int LENGTH_MAX    = 255;

    localparam int LEN_W         = $clog2(LENGTH_MAX + 1);
    localparam int TOKEN_LEN_MAX = 255;
    localparam int KW_IDX_W      = 3;
    localparam int KW_TABLE_SIZE = 8;
    localparam int KW_TEXT_CHARS = 8;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KW_TEXT_CHARS*8-1:0] KW_TEXT [KW_TABLE_SIZE] = '{
        "main", "if", "else", "for", "while", "int", "void", "printf"
    };
    localparam int KW_LEN [KW_TABLE_SIZE] = '{4, 2, 4, 3, 5, 3, 4, 6};

    localparam logic [7:0] CH_EQUAL = 8'h3D;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_INT,
        KIND_WORD,
        KIND_OP
    } kind_t;

    typedef enum logic [2:0] {
        CLS_BOUNDARY,
        CLS_INTEGER,
        CLS_KEYWORD,
        CLS_IDENT,
        CLS_OPERATOR,
        CLS_UNKNOWN
    } tok_class_t;

    typedef logic [LEN_W-1:0] len_t;
    typedef logic [KEYWORD_CHARS-1:0][7:0] text_buf_t;

    typedef struct packed {
        tok_class_t          cls;
        logic [7:0]          length;
        logic [KW_IDX_W-1:0] kidx;
        logic [7:0]          c1;
        logic [7:0]          c2;
    } tok_t;

    typedef struct packed {
        logic two;
        tok_t t0;
        tok_t t1;
    } qent_t;

endpackage

// File: rtl/core/ltc_front.sv
// Front end: accepts characters, tracks the pending token and classifies finished tokens.
// Depends on ltc_pkg; pushes one or two tokens per transaction into ltc_queue.
module ltc_front
    import ltc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_word_end,
    input  logic       q_ready,
    output logic       push_valid,
    output qent_t      push_entry
);

    kind_t     kind_reg, kind_next;
    len_t      len_reg, len_next;
    text_buf_t text_reg, text_next;

    kind_t     kind_a, kind_b;
    len_t      len_a, len_b;
    text_buf_t text_b;
    logic      taken;
    logic      emit_a, emit_b, emit_c;
    tok_t      tok_a, tok_b, tok_c;
    logic      accept;

    function automatic logic is_digit(logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], "_"};
    endfunction

    function automatic logic is_boundary(logic [7:0] c);
        return c inside {"(", ")", "{", "}", ",", ";"};
    endfunction

    function automatic logic is_operator(logic [7:0] c);
        return c inside {"+", "-", "*", "/", "=", "!", "<", ">"};
    endfunction

    function automatic logic [7:0] kw_byte(int i, int j);
        logic [7:0] b;
        b = 8'h00;
        if (j < KW_LEN[i]) begin
            b = KW_TEXT[i][(KW_LEN[i]-1-j)*8 +: 8];
        end
        return b;
    endfunction

    function automatic tok_t make_tok(tok_class_t cls, len_t len, logic [KW_IDX_W-1:0] kidx,
                                      logic [7:0] c1, logic [7:0] c2);
        tok_t t;
        t.cls    = cls;
        t.length = (int'(len) > TOKEN_LEN_MAX) ? 8'(TOKEN_LEN_MAX) : 8'(len);
        t.kidx   = kidx;
        t.c1     = c1;
        t.c2     = c2;
        return t;
    endfunction

    function automatic tok_t flush_tok(kind_t kind, len_t len, text_buf_t txt);
        tok_t                t;
        logic                hit;
        logic                same;
        logic [KW_IDX_W-1:0] idx;
        hit = 1'b0;
        idx = '0;
        for (int i = KW_TABLE_SIZE - 1; i >= 0; i--) begin
            if (i < KEYWORD_COUNT && KW_LEN[i] <= KEYWORD_CHARS && int'(len) == KW_LEN[i]) begin
                same = 1'b1;
                for (int j = 0; j < KEYWORD_CHARS; j++) begin
                    if (j < KW_LEN[i] && txt[j] != kw_byte(i, j)) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    hit = 1'b1;
                    idx = KW_IDX_W'(i);
                end
            end
        end
        case (kind)
            KIND_INT:  t = make_tok(CLS_INTEGER, len, '0, txt[0], 8'h00);
            KIND_WORD: t = hit ? make_tok(CLS_KEYWORD, len, idx, txt[0], 8'h00)
                               : make_tok(CLS_IDENT, len, '0, txt[0], 8'h00);
            KIND_OP:   t = make_tok(CLS_OPERATOR, len_t'(1), '0, txt[0], 8'h00);
            default:   t = '0;
        endcase
        return t;
    endfunction

    function automatic text_buf_t write_text(text_buf_t txt, len_t len, logic [7:0] c);
        text_buf_t r;
        r = txt;
        for (int k = 0; k < KEYWORD_CHARS; k++) begin
            if (int'(len) == k) begin
                r[k] = c;
            end
        end
        return r;
    endfunction

    function automatic len_t bump_len(len_t len);
        return (int'(len) < LENGTH_MAX) ? len + len_t'(1) : len;
    endfunction

    always_comb begin
        kind_a = kind_reg;
        len_a  = len_reg;
        text_b = text_reg;
        taken  = 1'b0;
        emit_a = 1'b0;
        tok_a  = '0;
        case (kind_reg)
            KIND_OP: begin
                emit_a = 1'b1;
                kind_a = KIND_NONE;
                len_a  = '0;
                if (s_char_in == CH_EQUAL) begin
                    tok_a = make_tok(CLS_OPERATOR, len_t'(2), '0, text_reg[0], s_char_in);
                    taken = 1'b1;
                end else begin
                    tok_a = flush_tok(kind_reg, len_reg, text_reg);
                end
            end
            KIND_INT, KIND_WORD: begin
                if (is_digit(s_char_in) || (kind_reg == KIND_WORD && is_alpha(s_char_in))) begin
                    text_b = write_text(text_reg, len_reg, s_char_in);
                    len_a  = bump_len(len_reg);
                    taken  = 1'b1;
                end else begin
                    tok_a  = flush_tok(kind_reg, len_reg, text_reg);
                    emit_a = 1'b1;
                    kind_a = KIND_NONE;
                    len_a  = '0;
                end
            end
            default: ;
        endcase

        kind_b = kind_a;
        len_b  = len_a;
        emit_b = 1'b0;
        tok_b  = '0;
        if (!taken) begin
            if (is_boundary(s_char_in)) begin
                emit_b = 1'b1;
                tok_b  = make_tok(CLS_BOUNDARY, len_t'(1), '0, s_char_in, 8'h00);
            end else if (is_digit(s_char_in) || is_alpha(s_char_in) ||
                         is_operator(s_char_in)) begin
                kind_b = is_digit(s_char_in) ? KIND_INT :
                         is_alpha(s_char_in) ? KIND_WORD : KIND_OP;
                text_b = write_text(text_reg, '0, s_char_in);
                len_b  = bump_len('0);
            end else begin
                emit_b = 1'b1;
                tok_b  = make_tok(CLS_UNKNOWN, len_t'(1), '0, s_char_in, 8'h00);
            end
        end

        emit_c    = s_word_end && (kind_b != KIND_NONE);
        tok_c     = flush_tok(kind_b, len_b, text_b);
        kind_next = emit_c ? KIND_NONE : kind_b;
        len_next  = emit_c ? '0 : len_b;
        text_next = text_b;
    end

    assign s_ready         = q_ready;
    assign accept          = s_valid && s_ready;
    assign push_valid      = accept && (emit_a || emit_b || emit_c);
    assign push_entry.two  = (emit_a && emit_b) || ((emit_a || emit_b) && emit_c);
    assign push_entry.t0   = emit_a ? tok_a : (emit_b ? tok_b : tok_c);
    assign push_entry.t1   = (emit_a && emit_b) ? tok_b : tok_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= KIND_NONE;
            len_reg  <= '0;
        end else if (accept) begin
            kind_reg <= kind_next;
            len_reg  <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            text_reg <= text_next;
        end
    end

endmodule

// File: rtl/core/ltc_queue.sv
// Short queue of token entries between the front and back ends.
// Depends on ltc_pkg for the entry type and depth.
module ltc_queue
    import ltc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    input  qent_t push_entry,
    output logic  q_ready,
    output logic  q_valid,
    output qent_t q_entry,
    input  logic  pop
);

    qent_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
    endfunction

    assign q_ready = (int'(count_reg) < QUEUE_DEPTH);
    assign q_valid = (count_reg != '0);
    assign q_entry = mem[rd_ptr_reg];
    assign do_push = push_valid && q_ready;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/core/ltc_back.sv
// Back end: takes queue entries and issues their tokens one per result transaction.
// Depends on ltc_pkg; holds the output register and the second token of a pair.
module ltc_back
    import ltc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  q_valid,
    input  qent_t q_entry,
    output logic  pop,
    output logic  m_valid,
    input  logic  m_ready,
    output tok_t  m_tok,
    output logic  m_last
);

    logic out_valid_reg, out_valid_next;
    logic hold_valid_reg, hold_valid_next;
    tok_t out_tok_reg, out_tok_next;
    tok_t hold_tok_reg, hold_tok_next;
    logic out_last_reg, out_last_next;
    logic load;

    assign load = !out_valid_reg || m_ready;
    assign pop  = load && !hold_valid_reg && q_valid;

    always_comb begin
        out_valid_next  = out_valid_reg;
        hold_valid_next = hold_valid_reg;
        out_tok_next    = out_tok_reg;
        out_last_next   = out_last_reg;
        hold_tok_next   = hold_tok_reg;
        if (load) begin
            if (hold_valid_reg) begin
                out_valid_next  = 1'b1;
                out_tok_next    = hold_tok_reg;
                out_last_next   = 1'b1;
                hold_valid_next = 1'b0;
            end else if (q_valid) begin
                out_valid_next  = 1'b1;
                out_tok_next    = q_entry.t0;
                out_last_next   = !q_entry.two;
                hold_valid_next = q_entry.two;
                hold_tok_next   = q_entry.t1;
            end else begin
                out_valid_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
        hold_tok_reg <= hold_tok_next;
    end

    assign m_valid = out_valid_reg;
    assign m_tok   = out_tok_reg;
    assign m_last  = out_last_reg;

endmodule

// File: rtl/core/lexical_token_classifier.sv
// Lexical token classifier: one character per cycle in while s_ready is high, classified tokens out.
// Path: the front end writes a token into the queue when the character ending it is accepted;
// the back end then loads it into its output register on m_. Throughput: one character per cycle while the
// queue has room; an item ending two tokens yields two results, which the four-entry queue absorbs.
// Reset: synchronous, active low; clears the pending token, the queue and the output
// valid. The token text buffer is not reset.
module lexical_token_classifier
    import ltc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_word_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_token_class,
    output logic [7:0] m_token_length,
    output logic [2:0] m_keyword_index,
    output logic [7:0] m_first_char,
    output logic [7:0] m_second_char,
    output logic       m_last_result
);

    logic  q_ready, q_valid, push_valid, pop;
    qent_t push_entry, q_entry;
    tok_t  m_tok;

    ltc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_in  (s_char_in),
        .s_word_end (s_word_end),
        .q_ready    (q_ready),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    ltc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .pop        (pop)
    );

    ltc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_tok   (m_tok),
        .m_last  (m_last_result)
    );

    assign m_token_class   = m_tok.cls;
    assign m_token_length  = m_tok.length;
    assign m_keyword_index = m_tok.kidx;
    assign m_first_char    = m_tok.c1;
    assign m_second_char   = m_tok.c2;

`ifndef SYNTHESIS
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_result) |=> m_valid)
        else $error("second token of a pair not issued");

    a_kw_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_token_class != CLS_KEYWORD) |-> (m_keyword_index == '0))
        else $error("keyword index on non-keyword token");

    a_second_char: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_second_char != 8'h00) |->
        (m_token_class == CLS_OPERATOR && m_token_length == 8'd2))
        else $error("second character outside two-character operator");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for lexical_token_classifier: a directed table, then random
// words, checked against a token predictor. Depends on ltc_pkg and the RTL only.
module tb_top
    import ltc_pkg::*;
();

    localparam int ITEM_TARGET = 850;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [2:0] KW_IF = 3'd1;
    localparam logic [2:0] KW_PRINTF = 3'd7;

    typedef struct packed {
        tok_class_t cls;
        logic [7:0] len;
        logic [2:0] kidx;
        logic [7:0] c1;
        logic [7:0] c2;
        logic       is_last;
    } tok_exp_t;

    typedef struct {
        logic [7:0] ch;
        logic       we;
        bit         typed;
        tok_class_t cls;
        logic [7:0] len;
        logic [2:0] kidx;
        logic [7:0] c1;
        logic [7:0] c2;
    } lex_row_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in = 8'h00;
    logic       s_word_end = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_token_class;
    logic [7:0] m_token_length;
    logic [2:0] m_keyword_index;
    logic [7:0] m_first_char;
    logic [7:0] m_second_char;
    logic       m_last_result;

    tok_exp_t   tok_expected[$];
    logic [7:0] word_buf[$];
    int         mismatches = 0;
    int         sent_cnt = 0;
    int         cycle_cnt = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         pressure_go = 1'b0;
    logic       hold_on = 1'b0;

    kind_t      pend_kind = KIND_NONE;
    logic [7:0] pend_text[KEYWORD_CHARS];
    int         pend_len = 0;

    string kw_names[KW_TABLE_SIZE] = '{
        "main", "if", "else", "for", "while", "int", "void", "printf"
    };
    string alpha_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string alnum_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string digit_set = "0123456789";
    string op_set = "+-*/=!<>";
    string bound_set = "(){},;";

    lex_row_t dir_rows[25] = '{
        '{"(", 1'b0, 1'b1, CLS_BOUNDARY, 8'd1, 3'd0, "(", 8'h00},
        '{"i", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"f", 1'b1, 1'b1, CLS_KEYWORD, 8'd2, KW_IF, "i", 8'h00},
        '{"4", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"2", 1'b1, 1'b1, CLS_INTEGER, 8'd2, 3'd0, "4", 8'h00},
        '{"<", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"=", 1'b1, 1'b1, CLS_OPERATOR, 8'd2, 3'd0, "<", "="},
        '{"+", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"a", 1'b1, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{8'hFF, 1'b0, 1'b1, CLS_UNKNOWN, 8'd1, 3'd0, 8'hFF, 8'h00},
        '{8'h00, 1'b1, 1'b1, CLS_UNKNOWN, 8'd1, 3'd0, 8'h00, 8'h00},
        '{"p", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"r", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"i", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"n", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"t", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"f", 1'b1, 1'b1, CLS_KEYWORD, 8'd6, KW_PRINTF, "p", 8'h00},
        '{"_", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"9", 1'b1, 1'b1, CLS_IDENT, 8'd2, 3'd0, "_", 8'h00},
        '{"!", 1'b1, 1'b1, CLS_OPERATOR, 8'd1, 3'd0, "!", 8'h00},
        '{";", 1'b1, 1'b1, CLS_BOUNDARY, 8'd1, 3'd0, ";", 8'h00},
        '{"7", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"x", 1'b1, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{"-", 1'b0, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00},
        '{")", 1'b1, 1'b0, CLS_BOUNDARY, 8'd0, 3'd0, 8'h00, 8'h00}
    };

    lexical_token_classifier u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_in       (s_char_in),
        .s_word_end      (s_word_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_class   (m_token_class),
        .m_token_length  (m_token_length),
        .m_keyword_index (m_keyword_index),
        .m_first_char    (m_first_char),
        .m_second_char   (m_second_char),
        .m_last_result   (m_last_result)
    );

    always #1 aclk = ~aclk;

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_bound(logic [7:0] c);
        return c == "(" || c == ")" || c == "{" || c == "}" || c == "," || c == ";";
    endfunction

    function automatic bit is_op(logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" ||
               c == "!" || c == "<" || c == ">";
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic void add_char(logic [7:0] c);
        word_buf.insert(word_buf.size(), c);
    endfunction

    function automatic void push_token(tok_class_t cls, int len, logic [2:0] kidx,
                                       logic [7:0] c1, logic [7:0] c2);
        tok_exp_t t;
        t.cls = cls;
        t.len = (len > TOKEN_LEN_MAX) ? 8'(TOKEN_LEN_MAX) : 8'(len);
        t.kidx = kidx;
        t.c1 = c1;
        t.c2 = c2;
        t.is_last = 1'b0;
        tok_expected.insert(tok_expected.size(), t);
    endfunction

    function automatic int keyword_hit();
        int i;
        int j;
        int kl;
        bit same;
        for (i = 0; i < KW_TABLE_SIZE && i < KEYWORD_COUNT; i++) begin
            kl = kw_names[i].len();
            if (kl != pend_len || kl > KEYWORD_CHARS) continue;
            same = 1'b1;
            for (j = 0; j < kl; j++) begin
                if (pend_text[j] != kw_names[i][j]) same = 1'b0;
            end
            if (same) return i;
        end
        return -1;
    endfunction

    function automatic void close_token();
        int k;
        case (pend_kind)
            KIND_INT: begin
                push_token(CLS_INTEGER, pend_len, 3'd0, pend_text[0], 8'h00);
            end
            KIND_WORD: begin
                k = keyword_hit();
                if (k >= 0) push_token(CLS_KEYWORD, pend_len, 3'(k), pend_text[0], 8'h00);
                else push_token(CLS_IDENT, pend_len, 3'd0, pend_text[0], 8'h00);
            end
            KIND_OP: begin
                push_token(CLS_OPERATOR, 1, 3'd0, pend_text[0], 8'h00);
            end
            default: ;
        endcase
        pend_kind = KIND_NONE;
        pend_len = 0;
    endfunction

    function automatic void grow(logic [7:0] c);
        if (pend_len < KEYWORD_CHARS) pend_text[pend_len] = c;
        if (pend_len < LENGTH_MAX) pend_len++;
    endfunction

    function automatic void start_token(kind_t kind, logic [7:0] c);
        pend_kind = kind;
        pend_len = 0;
        grow(c);
    endfunction

    function automatic int classify_char(logic [7:0] c, logic we);
        int first;
        bit taken;
        first = tok_expected.size();
        taken = 1'b0;
        case (pend_kind)
            KIND_OP: begin
                if (c == CH_EQUAL) begin
                    push_token(CLS_OPERATOR, 2, 3'd0, pend_text[0], c);
                    pend_kind = KIND_NONE;
                    pend_len = 0;
                    taken = 1'b1;
                end else begin
                    close_token();
                end
            end
            KIND_INT: begin
                if (is_digit(c)) begin
                    grow(c);
                    taken = 1'b1;
                end else begin
                    close_token();
                end
            end
            KIND_WORD: begin
                if (is_alpha(c) || is_digit(c)) begin
                    grow(c);
                    taken = 1'b1;
                end else begin
                    close_token();
                end
            end
            default: ;
        endcase
        if (!taken) begin
            if (is_bound(c)) push_token(CLS_BOUNDARY, 1, 3'd0, c, 8'h00);
            else if (is_digit(c)) start_token(KIND_INT, c);
            else if (is_alpha(c)) start_token(KIND_WORD, c);
            else if (is_op(c)) start_token(KIND_OP, c);
            else push_token(CLS_UNKNOWN, 1, 3'd0, c, 8'h00);
        end
        if (we && pend_kind != KIND_NONE) close_token();
        if (tok_expected.size() > first) tok_expected[tok_expected.size() - 1].is_last = 1'b1;
        return tok_expected.size() - first;
    endfunction

    task automatic report(string what, logic [7:0] got, logic [7:0] want);
        $display("MISMATCH at cycle %0d: %s got %0h want %0h", cycle_cnt, what, got, want);
        mismatches++;
    endtask

    task automatic check_token();
        tok_exp_t want;
        if (tok_expected.size() == 0) begin
            report("unexpected token, class", 8'(m_token_class), 8'h00);
            return;
        end
        want = tok_expected.pop_front();
        if (m_token_class !== want.cls) report("class", 8'(m_token_class), 8'(want.cls));
        if (m_token_length !== want.len) report("length", m_token_length, want.len);
        if (m_keyword_index !== want.kidx) report("keyword", 8'(m_keyword_index), 8'(want.kidx));
        if (m_first_char !== want.c1) report("first char", m_first_char, want.c1);
        if (m_second_char !== want.c2) report("second char", m_second_char, want.c2);
        if (m_last_result !== want.is_last) report("last", 8'(m_last_result), 8'(want.is_last));
    endtask

    // Hold the transaction until accepted, then advance the predictor.
    task automatic send_char(input logic [7:0] c, input logic we, output int made);
        int phase;
        if (sent_cnt >= $size(dir_rows)) begin
            phase = (sent_cnt - $size(dir_rows)) * 4 / (ITEM_TARGET - $size(dir_rows));
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 66; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 66; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
        end
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_char_in <= c;
        s_word_end <= we;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        made = classify_char(c, we);
        sent_cnt++;
    endtask

    task automatic build_word();
        int n_tok;
        int k;
        int n;
        string kw;
        word_buf.delete();
        n_tok = $urandom_range(1, 4);
        for (k = 0; k < n_tok; k++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    kw = kw_names[$urandom_range(0, KW_TABLE_SIZE - 1)];
                    for (n = 0; n < kw.len(); n++) add_char(kw[n]);
                    if ($urandom_range(0, 3) == 0) add_char(pick(alnum_set));
                end
                2, 3: begin
                    add_char(pick(alpha_set));
                    repeat ($urandom_range(0, 7)) add_char(pick(alnum_set));
                end
                4: begin
                    repeat ($urandom_range(1, 5)) add_char(pick(digit_set));
                end
                5, 6: begin
                    add_char(pick(op_set));
                    if ($urandom_range(0, 1) == 1) add_char(CH_EQUAL);
                end
                7: add_char(pick(bound_set));
                8: add_char(8'($urandom_range(0, 255)));
                default: begin
                    add_char(pick(op_set));
                    add_char(pick(op_set));
                end
            endcase
        end
    endtask

    task automatic build_long_word();
        word_buf.delete();
        add_char(pick(alpha_set));
        repeat ($urandom_range(LENGTH_MAX, LENGTH_MAX + 10)) add_char(pick(alnum_set));
    endtask

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) check_token();
        if (!aresetn || hold_on) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin : receiver_hold
        wait (pressure_go);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    initial begin : stimulus
        int i;
        int made;
        bit long_sent;
        lex_row_t row;
        long_sent = 1'b0;
        for (i = 0; i < KEYWORD_CHARS; i++) pend_text[i] = 8'h00;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_char(row.ch, row.we, made);
            if (row.typed) begin
                if (made != 1) report("directed token count", 8'(made), 8'd1);
                else tok_expected[tok_expected.size() - 1] =
                    '{row.cls, row.len, row.kidx, row.c1, row.c2, 1'b1};
            end
        end

        while (sent_cnt < ITEM_TARGET) begin
            if (!pressure_go && sent_cnt >= 60) pressure_go = 1'b1;
            if (!long_sent && sent_cnt >= 400) begin
                build_long_word();
                long_sent = 1'b1;
            end else if ($urandom_range(0, 9) == 0) begin
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), made);
                continue;
            end else begin
                build_word();
            end
            for (i = 0; i < word_buf.size(); i++)
                send_char(word_buf[i], i == word_buf.size() - 1, made);
        end
        s_valid <= 1'b0;

        while (tok_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
